/* rtl/sfla_pkg.sv */
`timescale 1ns / 1ps

package sfla_pkg;

    // Field widths of the channels
    localparam int CMD_W  = 1;
    localparam int TYPE_W = 8;
    localparam int SLOT_W = 10;
    localparam int NAME_W = 32;
    localparam int LIVE_W = 11;

    // Parameter defaults
    localparam int CAPACITY_DEF  = 1024;
    localparam int TYPE_BITS_DEF = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;   // write one sweep entry and advance
        logic issue;    // latch the input word and start the memory reads
        logic commit;   // update state and load the result register
    } t_sfla_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last; // sweep is at the last entry
        logic out_busy; // result register full and stalled
    } t_sfla_stat;

endpackage

/* rtl/sfla_ctrl.sv */
`timescale 1ns / 1ps

module sfla_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sfla_pkg::t_sfla_stat i_stat,
    output sfla_pkg::t_sfla_cmd  o_cmd,
    output logic                o_in_stall
);
    import sfla_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_in_stall;

    always_comb begin
        o_cmd        = '0;
        o_cmd.clr_en = (r_state == S_CLEAR);
        o_cmd.issue  = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
        o_cmd.commit = (r_state == S_EXEC) && !i_stat.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.issue) begin
                        r_state    <= S_EXEC;
                        r_in_stall <= 1'b1;
                    end
                end
                S_EXEC: begin
                    // hold while the previous result still waits
                    if (o_cmd.commit) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_CLEAR;
                    r_in_stall <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

/* rtl/sfla_dp.sv */
`timescale 1ns / 1ps

module sfla_dp #(
    parameter int CAPACITY  = sfla_pkg::CAPACITY_DEF,
    parameter int TYPE_BITS = sfla_pkg::TYPE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfla_pkg::t_sfla_cmd         i_cmd,
    output sfla_pkg::t_sfla_stat        o_stat,
    input  logic [sfla_pkg::CMD_W-1:0]  i_command,
    input  logic [sfla_pkg::TYPE_W-1:0] i_entity_type,
    input  logic [sfla_pkg::SLOT_W-1:0] i_slot_index,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_ok,
    output logic [sfla_pkg::SLOT_W-1:0] o_granted_slot,
    output logic [sfla_pkg::NAME_W-1:0] o_name_number,
    output logic [sfla_pkg::LIVE_W-1:0] o_live_slots
);
    import sfla_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = $clog2(CAPACITY + 1);

    // Memories
    logic [AW-1:0]        r_stack_mem [CAPACITY];
    logic                 r_flag_mem  [CAPACITY];
    logic [TYPE_BITS-1:0] r_type_mem  [CAPACITY];

    // Control state
    logic [AW-1:0]     r_clr_addr;
    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     r_live;
    logic [NAME_W-1:0] r_name;
    logic              r_out_valid;

    // Latched command word and read data
    logic [CMD_W-1:0]     r_cmd;
    logic [TYPE_BITS-1:0] r_type;
    logic [AW-1:0]        r_idx;
    logic                 r_idx_ok;
    logic [AW-1:0]        r_stack_q;
    logic                 r_flag_q;

    // Result register
    logic              r_ok;
    logic [SLOT_W-1:0] r_slot;
    logic [NAME_W-1:0] r_name_out;
    logic [LIVE_W-1:0] r_live_out;

    logic [31:0]   idx_ext;
    logic [31:0]   type_ext;
    logic [31:0]   slot_ext;
    logic [31:0]   live_ext;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] top_addr;
    logic          idx_in_range;
    logic          stack_empty;
    logic          create_ok;
    logic          remove_ok;
    logic          push_ok;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] n_live;

    always_comb begin
        idx_ext      = 32'(i_slot_index);
        type_ext     = 32'(i_entity_type);
        rd_idx       = idx_ext[AW-1:0];
        idx_in_range = idx_ext < 32'(CAPACITY);
        top_addr     = AW'(r_depth - DW'(1));
        stack_empty  = (r_depth == '0);
        create_ok    = (r_cmd == CMD_CREATE) && !stack_empty;
        remove_ok    = (r_cmd == CMD_REMOVE) && r_idx_ok && r_flag_q;
        push_ok      = remove_ok && (r_depth < DW'(CAPACITY));

        n_depth = r_depth;
        if (create_ok) begin
            n_depth = r_depth - DW'(1);
        end else if (push_ok) begin
            n_depth = r_depth + DW'(1);
        end

        n_live = r_live;
        if (create_ok) begin
            n_live = r_live + DW'(1);
        end else if (remove_ok && (r_live != '0)) begin
            n_live = r_live - DW'(1);
        end

        slot_ext = 32'(r_stack_q);
        live_ext = 32'(n_live);
    end

    // Free stack: sweep fill, push on remove, read top on issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_stack_mem[r_clr_addr] <= AW'(CAPACITY - 1) - r_clr_addr;
        end else if (i_cmd.commit && push_ok) begin
            r_stack_mem[r_depth[AW-1:0]] <= r_idx;
        end
        if (i_cmd.issue) begin
            r_stack_q <= r_stack_mem[top_addr];
        end
    end

    // Active flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_flag_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.commit && create_ok) begin
            r_flag_mem[r_stack_q] <= 1'b1;
        end else if (i_cmd.commit && remove_ok) begin
            r_flag_mem[r_idx] <= 1'b0;
        end
        if (i_cmd.issue) begin
            r_flag_q <= r_flag_mem[rd_idx];
        end
    end

    // Type codes of created slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && create_ok) begin
            r_type_mem[r_stack_q] <= r_type;
        end
    end

    // Latch the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_cmd    <= i_command;
            r_type   <= type_ext[TYPE_BITS-1:0];
            r_idx    <= rd_idx;
            r_idx_ok <= idx_in_range;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok       <= create_ok || remove_ok;
            r_slot     <= create_ok ? slot_ext[SLOT_W-1:0] : '0;
            r_name_out <= create_ok ? r_name : '0;
            r_live_out <= live_ext[LIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_depth     <= DW'(CAPACITY);
            r_live      <= '0;
            r_name      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.commit) begin
                r_depth     <= n_depth;
                r_live      <= n_live;
                r_out_valid <= 1'b1;
                if (create_ok) begin
                    r_name <= r_name + NAME_W'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.clr_last = (r_clr_addr == AW'(CAPACITY - 1));
        o_stat.out_busy = r_out_valid && i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_ok;
    assign o_granted_slot = r_slot;
    assign o_name_number  = r_name_out;
    assign o_live_slots   = r_live_out;

endmodule

/* rtl/slot_free_list_allocator_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Word
// -------   -----------------------   ------------------------------------------------
// in        i_in_valid / o_in_stall   i_command, i_entity_type, i_slot_index
// out       o_out_valid / i_out_stall o_ok, o_granted_slot, o_name_number, o_live_slots
//
// One command at a time: the stack and flag memories are read in the
// accept cycle and written back at commit, and the next command needs
// the updated stack depth.
// After reset a sweep fills the free stack and clears the flags, every entry,
// with o_in_stall high.
// A stalled result holds the block in its write-back cycle until taken.

module slot_free_list_allocator_top #(
    parameter int CAPACITY  = sfla_pkg::CAPACITY_DEF,
    parameter int TYPE_BITS = sfla_pkg::TYPE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sfla_pkg::CMD_W-1:0]  i_command,
    input  logic [sfla_pkg::TYPE_W-1:0] i_entity_type,
    input  logic [sfla_pkg::SLOT_W-1:0] i_slot_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_ok,
    output logic [sfla_pkg::SLOT_W-1:0] o_granted_slot,
    output logic [sfla_pkg::NAME_W-1:0] o_name_number,
    output logic [sfla_pkg::LIVE_W-1:0] o_live_slots
);
    import sfla_pkg::*;

    t_sfla_cmd  cmd;
    t_sfla_stat stat;

    sfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sfla_dp #(
        .CAPACITY  (CAPACITY),
        .TYPE_BITS (TYPE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_command      (i_command),
        .i_entity_type  (i_entity_type),
        .i_slot_index   (i_slot_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_ok           (o_ok),
        .o_granted_slot (o_granted_slot),
        .o_name_number  (o_name_number),
        .o_live_slots   (o_live_slots)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a word was in flight");

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_en, cmd.issue, cmd.commit}))
        else $error("controller issued overlapping commands");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_granted_slot == '0 && o_name_number == '0))
        else $error("failed command carries a slot or name");

endmodule

/* verif/slot_free_list_allocator_top_tb.sv */
`timescale 1ns / 1ps

module slot_free_list_allocator_top_tb;
    import sfla_pkg::*;

    localparam int POOL_SLOTS  = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 7;
    localparam int REPORT_MAX  = 200;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [NAME_W-1:0] name;
        logic [LIVE_W-1:0] live;
    } t_alloc_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_command;
    logic [TYPE_W-1:0] i_entity_type;
    logic [SLOT_W-1:0] i_slot_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_ok;
    logic [SLOT_W-1:0] o_granted_slot;
    logic [NAME_W-1:0] o_name_number;
    logic [LIVE_W-1:0] o_live_slots;

    // Shadow of the pool: free stack, active flags, live count, name counter
    logic [SLOT_W-1:0] free_slots [POOL_SLOTS];
    int unsigned       free_top;
    bit                in_use [POOL_SLOTS];
    logic [LIVE_W-1:0] live_total;
    logic [NAME_W-1:0] name_seq;

    t_alloc_word       expected_words [$];
    int unsigned       mismatches = 0;
    int unsigned       cycles = 0;
    bit                calm = 1'b0;

    slot_free_list_allocator_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_entity_type  (i_entity_type),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ok           (o_ok),
        .o_granted_slot (o_granted_slot),
        .o_name_number  (o_name_number),
        .o_live_slots   (o_live_slots)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("slot_free_list_allocator_top verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Pop on create, push back on remove of an active slot
    function automatic t_alloc_word allocate_or_release(logic [CMD_W-1:0] cmd,
                                                        logic [SLOT_W-1:0] idx);
        t_alloc_word w;
        w = '0;
        if (cmd == CMD_CREATE) begin
            if (free_top != 0) begin
                w.slot = free_slots[SLOT_W'(free_top - 1)];
                free_top--;
                in_use[w.slot] = 1'b1;
                live_total = live_total + LIVE_W'(1);
                w.ok = 1'b1;
                w.name = name_seq;
                name_seq = name_seq + NAME_W'(1);
            end
        end else if (in_use[idx]) begin
            in_use[idx] = 1'b0;
            if (free_top < POOL_SLOTS) begin
                free_slots[SLOT_W'(free_top)] = idx;
                free_top++;
            end
            if (live_total != 0) begin
                live_total = live_total - LIVE_W'(1);
            end
            w.ok = 1'b1;
        end
        w.live = live_total;
        return w;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int unsigned start;
        start = $urandom_range(POOL_SLOTS-1);
        for (int k = 0; k < POOL_SLOTS; k++) begin
            if (in_use[SLOT_W'((start+k) % POOL_SLOTS)]) begin
                return SLOT_W'((start+k) % POOL_SLOTS);
            end
        end
        return SLOT_W'(start);
    endfunction

    function automatic void check_field(string field, logic [NAME_W-1:0] want,
                                        logic [NAME_W-1:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_MAX) begin
                $error("%s: expected %0d, got %0d", field, want, got);
            end
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_alloc_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("ok", NAME_W'(want.ok), NAME_W'(o_ok));
                check_field("granted_slot", NAME_W'(want.slot), NAME_W'(o_granted_slot));
                check_field("name_number", want.name, o_name_number);
                check_field("live_slots", NAME_W'(want.live), NAME_W'(o_live_slots));
            end
        end
    end

    // Leave valid high after acceptance; a drain, or an idle gap in the next call, lowers it
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [TYPE_W-1:0] etype,
                             logic [SLOT_W-1:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entity_type <= etype;
        i_slot_index  <= idx;
        do @(posedge i_clk); while (o_in_stall);
        expected_words.push_back(allocate_or_release(cmd, idx));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(CMD_CREATE, 8'h00, 10'h000);
        send_word(CMD_CREATE, 8'hFF, 10'h3FF);
        send_word(CMD_CREATE, 8'h5A, 10'h155);
        send_word(CMD_CREATE, 8'hA5, 10'h2AA);
        send_word(CMD_REMOVE, 8'h00, 10'd1);
        // second remove of the same slot finds it inactive
        send_word(CMD_REMOVE, 8'hFF, 10'd1);
        // freed slot comes back first
        send_word(CMD_CREATE, 8'h3C, 10'h000);
        send_word(CMD_REMOVE, 8'h00, 10'h3FF);
        send_word(CMD_REMOVE, 8'h00, 10'd0);
        send_word(CMD_REMOVE, 8'h00, 10'd2);
        send_word(CMD_CREATE, 8'hC3, 10'h3FF);
        send_word(CMD_CREATE, 8'h81, 10'h000);
        send_word(CMD_REMOVE, 8'hFF, 10'd3);
        send_word(CMD_REMOVE, 8'hFF, 10'd3);
    endtask

    task automatic test_pool_exhaustion();
        wait_for_drain();
        while (free_top != 0) begin
            send_word(CMD_CREATE, TYPE_W'($urandom_range(255)),
                      SLOT_W'($urandom_range(POOL_SLOTS-1)));
        end
        // create on an empty stack fails
        repeat (4) send_word(CMD_CREATE, TYPE_W'($urandom_range(255)),
                             SLOT_W'($urandom_range(POOL_SLOTS-1)));
        repeat (3) send_word(CMD_REMOVE, TYPE_W'($urandom_range(255)), pick_live_slot());
        send_word(CMD_CREATE, TYPE_W'($urandom_range(255)), 10'h000);
    endtask

    task automatic test_random_traffic();
        int unsigned remove_pct;
        for (int n = 0; n < 560; n++) begin
            calm = (n < 200);
            if (n == 300) begin
                wait_for_drain();
            end
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: remove_pct = 20;
                    1: remove_pct = 50;
                    default: remove_pct = 80;
                endcase
            end
            if ($urandom_range(99) < remove_pct) begin
                if ($urandom_range(99) < 85) begin
                    send_word(CMD_REMOVE, TYPE_W'($urandom_range(255)), pick_live_slot());
                end else begin
                    send_word(CMD_REMOVE, TYPE_W'($urandom_range(255)),
                              SLOT_W'($urandom_range(POOL_SLOTS-1)));
                end
            end else begin
                send_word(CMD_CREATE, TYPE_W'($urandom_range(255)),
                          SLOT_W'($urandom_range(POOL_SLOTS-1)));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < POOL_SLOTS; k++) begin
            free_slots[SLOT_W'(k)] = SLOT_W'(POOL_SLOTS - 1 - k);
            in_use[SLOT_W'(k)]     = 1'b0;
        end
        free_top   = POOL_SLOTS;
        live_total = '0;
        name_seq   = '0;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_CREATE;
        i_entity_type <= '0;
        i_slot_index  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pool_exhaustion();
        test_random_traffic();

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("slot_free_list_allocator_top verification clean");
        end else begin
            $display("slot_free_list_allocator_top verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sfla_pkg.sv
rtl/sfla_ctrl.sv
rtl/sfla_dp.sv
rtl/slot_free_list_allocator_top.sv
verif/slot_free_list_allocator_top_tb.sv
